// ===== rtl/core/wrte_pkg.sv =====
// ----------------------------------------------------------------------------
// wrte_pkg: shared types and constants for the window regression estimator
// Field widths, sum widths sized for the largest window, datapath action and
// multiply operand codes, and the command/status structs.
// ----------------------------------------------------------------------------
package wrte_pkg;

	localparam int WINDOW_DEF = 20;

	localparam int X_W    = 32;   // sample time
	localparam int Y_W    = 14;   // percent in hundredths
	localparam int SX_W   = 40;   // sum of x
	localparam int SY_W   = 24;   // sum of y
	localparam int SXY_W  = 56;   // sum of x*y
	localparam int SXX_W  = 70;   // exact sum of x*x
	localparam int D_W    = 74;   // n*Sxx - Sx^2
	localparam int NMAG_W = 56;   // |n*Sxy - Sx*Sy|
	localparam int PMAG_W = 20;   // |10000*n - Sy|
	localparam int MA_W   = 74;   // multiplicand
	localparam int MB_W   = 40;   // multiplier (consumed one bit per cycle)
	localparam int P_W    = 96;   // product and dividend
	localparam int DEN_W  = 62;   // divisor

	localparam int PCT_FULL = 10000;

	localparam logic [X_W-1:0] THR_RST   = 32'd800000;
	localparam logic [X_W-1:0] NOEST_RST = 32'd60000;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NOEST = 2'd1;

	// datapath actions
	localparam int ACT_W = 5;
	localparam logic [ACT_W-1:0] ACT_NONE       = 5'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD       = 5'd1;
	localparam logic [ACT_W-1:0] ACT_SET_ORIGIN = 5'd2;
	localparam logic [ACT_W-1:0] ACT_RD_HEAD    = 5'd3;
	localparam logic [ACT_W-1:0] ACT_DROP       = 5'd4;
	localparam logic [ACT_W-1:0] ACT_CUR_OLD    = 5'd5;
	localparam logic [ACT_W-1:0] ACT_REBASE     = 5'd6;
	localparam logic [ACT_W-1:0] ACT_SUMS       = 5'd7;
	localparam logic [ACT_W-1:0] ACT_ACC_XY     = 5'd8;
	localparam logic [ACT_W-1:0] ACT_ACC_XX     = 5'd9;
	localparam logic [ACT_W-1:0] ACT_W_RD       = 5'd10;
	localparam logic [ACT_W-1:0] ACT_W_FIX      = 5'd11;
	localparam logic [ACT_W-1:0] ACT_W_NEXT     = 5'd12;
	localparam logic [ACT_W-1:0] ACT_LOG_X      = 5'd13;
	localparam logic [ACT_W-1:0] ACT_R1         = 5'd14;
	localparam logic [ACT_W-1:0] ACT_D          = 5'd15;
	localparam logic [ACT_W-1:0] ACT_N          = 5'd16;
	localparam logic [ACT_W-1:0] ACT_NUM        = 5'd17;
	localparam logic [ACT_W-1:0] ACT_DIV        = 5'd18;
	localparam logic [ACT_W-1:0] ACT_RES_EST    = 5'd19;
	localparam logic [ACT_W-1:0] ACT_RES_NOEST  = 5'd20;

	// multiply operand selects
	localparam int MOP_W = 4;
	localparam logic [MOP_W-1:0] MOP_XY      = 4'd0;
	localparam logic [MOP_W-1:0] MOP_XX      = 4'd1;
	localparam logic [MOP_W-1:0] MOP_N_SXX   = 4'd2;
	localparam logic [MOP_W-1:0] MOP_SX_SX   = 4'd3;
	localparam logic [MOP_W-1:0] MOP_N_SXY   = 4'd4;
	localparam logic [MOP_W-1:0] MOP_SX_SY   = 4'd5;
	localparam logic [MOP_W-1:0] MOP_SX_NMAG = 4'd6;
	localparam logic [MOP_W-1:0] MOP_D_PMAG  = 4'd7;
	localparam logic [MOP_W-1:0] MOP_N_NMAG  = 4'd8;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             mul_start;
		logic [MOP_W-1:0] mop;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic cnt_zero;
		logic cnt_full;
		logic cnt_lt2;
		logic old_below;
		logic walk_last;
		logic d_zero;
		logic n_eq;
		logic mul_busy;
		logic div_busy;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/core/window_regression_time_estimator.sv =====
// ----------------------------------------------------------------------------
// window_regression_time_estimator: remaining-time estimate from a sliding
// least-squares fit over logged progress samples.
//
//   channel   handshake             payload
//   in        in_valid / in_ready   mode, now_ms, pct_done
//   out       out_valid / out_ready remaining_ms, has_estimate
//   cfg       cfg_we                cfg_index, cfg_data
//
// One request at a time. A log adds the new sample to the sums, and first takes
// the oldest sample out when the window is full; a log that rebases walks the
// window and adds every kept sample back into the sums. A query runs through
// the bit-serial multiplier (seven products) and the restoring divider.
// A query result sits in the output register while the next request is
// taken; a further query waits there until it drains.
// Reset is asynchronous and empties the window; no clearing pass.
// ----------------------------------------------------------------------------
module window_regression_time_estimator #(
	parameter int WINDOW = wrte_pkg::WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [wrte_pkg::X_W-1:0]       now_ms,
	input  logic [wrte_pkg::Y_W-1:0]       pct_done,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [wrte_pkg::X_W-1:0]       remaining_ms,
	output logic                           has_estimate,
	input  logic                           cfg_we,
	input  logic [wrte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wrte_pkg::X_W-1:0]       cfg_data
);

	logic [wrte_pkg::X_W-1:0] thr_q;
	logic [wrte_pkg::X_W-1:0] noest_q;
	wrte_pkg::cmd_t           cmd;
	wrte_pkg::sts_t           sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= wrte_pkg::THR_RST;
			noest_q <= wrte_pkg::NOEST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wrte_pkg::CFG_THR:   thr_q   <= cfg_data;
				wrte_pkg::CFG_NOEST: noest_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	wrte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wrte_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.thr          (thr_q),
		.noest        (noest_q),
		.mode         (mode),
		.now_ms       (now_ms),
		.pct_done     (pct_done),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.remaining_ms (remaining_ms),
		.has_estimate (has_estimate)
	);

`ifndef SYNTH
	a_mul_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy)
		else $error("multiply started while busy");

	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == wrte_pkg::ACT_RES_EST || cmd.act == wrte_pkg::ACT_RES_NOEST)
		|-> !sts.out_busy)
		else $error("result written over a pending result");

	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!sts.mul_busy && !sts.div_busy))
		else $error("ready while arithmetic in flight");
`endif

endmodule

// ===== rtl/core/wrte_mul.sv =====
// ----------------------------------------------------------------------------
// wrte_mul: shift-add multiplier
// One multiplier bit per cycle; finishes as soon as the remaining bits are zero.
// ----------------------------------------------------------------------------
module wrte_mul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wrte_pkg::MA_W-1:0] a,
	input  logic [wrte_pkg::MB_W-1:0] b,
	output logic                      busy,
	output logic [wrte_pkg::P_W-1:0]  p
);

	logic [wrte_pkg::P_W-1:0]  a_q;
	logic [wrte_pkg::MB_W-1:0] b_q;
	logic [wrte_pkg::P_W-1:0]  p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (start) begin
			b_q <= b;
		end else if (b_q != '0) begin
			b_q <= b_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= wrte_pkg::P_W'(a);
			p_q <= '0;
		end else if (b_q != '0) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= a_q << 1;
		end
	end

	assign busy = (b_q != '0);
	assign p    = p_q;

endmodule

// ===== rtl/core/wrte_div.sv =====
// ----------------------------------------------------------------------------
// wrte_div: restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrte_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [wrte_pkg::P_W-1:0]   num,
	input  logic [wrte_pkg::DEN_W-1:0] den,
	output logic                       busy,
	output logic [wrte_pkg::P_W-1:0]   q
);

	localparam int CNT_W = $clog2(wrte_pkg::P_W + 1);

	logic [CNT_W-1:0]           cnt_q;
	logic [wrte_pkg::P_W-1:0]   nq_q;    // dividend shifts out, quotient shifts in
	logic [wrte_pkg::DEN_W-1:0] r_q;
	logic [wrte_pkg::DEN_W-1:0] den_q;
	logic [wrte_pkg::DEN_W:0]   r2;
	logic                       take;

	assign r2   = {r_q, nq_q[wrte_pkg::P_W-1]};
	assign take = (r2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(wrte_pkg::P_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			r_q   <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			r_q  <= take ? wrte_pkg::DEN_W'(r2 - {1'b0, den_q}) : wrte_pkg::DEN_W'(r2);
			nq_q <= {nq_q[wrte_pkg::P_W-2:0], take};
		end
	end

	assign busy = (cnt_q != '0);
	assign q    = nq_q;

endmodule

// ===== rtl/core/wrte_dp.sv =====
// ----------------------------------------------------------------------------
// wrte_dp: estimator datapath
// Sample window memory, running sums, fit terms, shared multiplier and
// divider, and the result register. Driven by action codes from the FSM.
// ----------------------------------------------------------------------------
module wrte_dp #(
	parameter int WINDOW = wrte_pkg::WINDOW_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  wrte_pkg::cmd_t           cmd,
	output wrte_pkg::sts_t           sts,
	input  logic [wrte_pkg::X_W-1:0] thr,
	input  logic [wrte_pkg::X_W-1:0] noest,
	input  logic                     mode,
	input  logic [wrte_pkg::X_W-1:0] now_ms,
	input  logic [wrte_pkg::Y_W-1:0] pct_done,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [wrte_pkg::X_W-1:0] remaining_ms,
	output logic                     has_estimate
);

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int M_W   = wrte_pkg::X_W + wrte_pkg::Y_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);

	// window memory: {time, pct}
	logic [M_W-1:0] mem [WINDOW];
	logic [M_W-1:0] rdata_q;
	logic           mem_we, mem_re;
	logic [IDX_W-1:0] mem_wa, mem_ra;
	logic [M_W-1:0]   mem_wd;

	logic                        mode_q;
	logic [wrte_pkg::X_W-1:0]    now_q;
	logic [wrte_pkg::Y_W-1:0]    pct_q;
	logic [wrte_pkg::X_W-1:0]    origin_q;
	logic [IDX_W-1:0]            head_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [wrte_pkg::SX_W-1:0]   sx_q;
	logic [wrte_pkg::SXX_W-1:0]  sxx_q;
	logic [wrte_pkg::SY_W-1:0]   sy_q;
	logic [wrte_pkg::SXY_W-1:0]  sxy_q;
	logic [wrte_pkg::X_W-1:0]    ox_q;
	logic [wrte_pkg::Y_W-1:0]    oy_q;
	logic [wrte_pkg::X_W-1:0]    curx_q;
	logic [wrte_pkg::Y_W-1:0]    cury_q;
	logic                        sub_q;
	logic [IDX_W-1:0]            k_q;
	logic [CNT_W-1:0]            rem_q;
	logic [wrte_pkg::P_W-1:0]    r1_q;
	logic [wrte_pkg::D_W-1:0]    d_q;
	logic                        nneg_q;
	logic [wrte_pkg::NMAG_W-1:0] nmag_q;
	logic [wrte_pkg::P_W-1:0]    num_q;
	logic                        numneg_q;
	logic                        out_valid_q;
	logic [wrte_pkg::X_W-1:0]    est_q;
	logic                        has_q;

	logic [wrte_pkg::X_W-1:0]    rdx, fix_x, x_log, xnow;
	logic [wrte_pkg::Y_W-1:0]    rdy;
	logic [CNT_W:0]              slot_sum;
	logic [IDX_W-1:0]            slot, head_inc, k_inc;
	logic [wrte_pkg::MA_W-1:0]   mul_a;
	logic [wrte_pkg::MB_W-1:0]   mul_b;
	logic                        mul_busy, div_busy;
	logic [wrte_pkg::P_W-1:0]    mul_p, div_q;
	logic [wrte_pkg::PMAG_W-1:0] pfull, sy20, pmag;
	logic                        pneg;
	logic [wrte_pkg::P_W-1:0]    t_sum, t_d21, q_sub;
	logic [wrte_pkg::P_W:0]      t_d12;
	logic [wrte_pkg::P_W-1:0]    num_d;
	logic                        numneg_d;
	logic [wrte_pkg::X_W-1:0]    est_d;

	assign rdx      = rdata_q[M_W-1:wrte_pkg::Y_W];
	assign rdy      = rdata_q[wrte_pkg::Y_W-1:0];
	assign fix_x    = rdx - ox_q;
	assign x_log    = now_q - origin_q;
	assign xnow     = now_q - origin_q;
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign k_inc    = (k_q == LAST_IDX) ? '0 : k_q + 1'b1;
	assign slot_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(cnt_q);
	assign slot     = (slot_sum >= (CNT_W+1)'(WINDOW)) ?
	                  IDX_W'(slot_sum - (CNT_W+1)'(WINDOW)) : IDX_W'(slot_sum);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = k_q;
		mem_wd = {fix_x, rdy};
		if (cmd.act == wrte_pkg::ACT_W_FIX) begin
			mem_we = 1'b1;
		end else if (cmd.act == wrte_pkg::ACT_LOG_X) begin
			mem_we = 1'b1;
			mem_wa = slot;
			mem_wd = {x_log, pct_q};
		end
		mem_re = (cmd.act == wrte_pkg::ACT_RD_HEAD) || (cmd.act == wrte_pkg::ACT_W_RD);
		mem_ra = (cmd.act == wrte_pkg::ACT_RD_HEAD) ? head_q : k_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	// |10000*n - Sy|; Sy stays below 2^19 for any window size in range
	assign sy20  = wrte_pkg::PMAG_W'(sy_q);
	assign pfull = wrte_pkg::PMAG_W'(cnt_q) * wrte_pkg::PMAG_W'(wrte_pkg::PCT_FULL);
	assign pneg  = (pfull < sy20);
	assign pmag  = pneg ? sy20 - pfull : pfull - sy20;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mop)
			wrte_pkg::MOP_XY: begin
				mul_a = wrte_pkg::MA_W'(curx_q);
				mul_b = wrte_pkg::MB_W'(cury_q);
			end
			wrte_pkg::MOP_XX: begin
				mul_a = wrte_pkg::MA_W'(curx_q);
				mul_b = wrte_pkg::MB_W'(curx_q);
			end
			wrte_pkg::MOP_N_SXX: begin
				mul_a = wrte_pkg::MA_W'(sxx_q);
				mul_b = wrte_pkg::MB_W'(cnt_q);
			end
			wrte_pkg::MOP_SX_SX: begin
				mul_a = wrte_pkg::MA_W'(sx_q);
				mul_b = wrte_pkg::MB_W'(sx_q);
			end
			wrte_pkg::MOP_N_SXY: begin
				mul_a = wrte_pkg::MA_W'(sxy_q);
				mul_b = wrte_pkg::MB_W'(cnt_q);
			end
			wrte_pkg::MOP_SX_SY: begin
				mul_a = wrte_pkg::MA_W'(sx_q);
				mul_b = wrte_pkg::MB_W'(sy_q);
			end
			wrte_pkg::MOP_SX_NMAG: begin
				mul_a = wrte_pkg::MA_W'(nmag_q);
				mul_b = wrte_pkg::MB_W'(sx_q);
			end
			wrte_pkg::MOP_D_PMAG: begin
				mul_a = wrte_pkg::MA_W'(d_q);
				mul_b = wrte_pkg::MB_W'(pmag);
			end
			wrte_pkg::MOP_N_NMAG: begin
				mul_a = wrte_pkg::MA_W'(nmag_q);
				mul_b = wrte_pkg::MB_W'(cnt_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	wrte_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.p      (mul_p)
	);

	wrte_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.act == wrte_pkg::ACT_DIV),
		.num    (num_q),
		.den    (mul_p[wrte_pkg::DEN_W-1:0]),
		.busy   (div_busy),
		.q      (div_q)
	);

	// numerator: Sx*|N| combined with D*|P| by sign
	assign t_sum = r1_q + mul_p;
	assign t_d12 = {1'b0, r1_q} - {1'b0, mul_p};
	assign t_d21 = mul_p - r1_q;

	always_comb begin
		if (nneg_q == pneg) begin
			num_d    = t_sum;
			numneg_d = 1'b0;
		end else if (!t_d12[wrte_pkg::P_W]) begin
			num_d    = t_d12[wrte_pkg::P_W-1:0];
			numneg_d = 1'b0;
		end else begin
			num_d    = t_d21;
			numneg_d = 1'b1;
		end
	end

	assign q_sub = div_q - wrte_pkg::P_W'(xnow);

	always_comb begin
		if (numneg_q) begin
			est_d = '0;
		end else if (div_q[wrte_pkg::P_W-1:wrte_pkg::X_W] == '0 &&
		             div_q[wrte_pkg::X_W-1:0] <= xnow) begin
			est_d = '0;
		end else if (q_sub[wrte_pkg::P_W-1:wrte_pkg::X_W] != '0) begin
			est_d = '1;
		end else begin
			est_d = q_sub[wrte_pkg::X_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q    <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			sx_q        <= '0;
			sxx_q       <= '0;
			sy_q        <= '0;
			sxy_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.act)
				wrte_pkg::ACT_SET_ORIGIN: origin_q <= now_q;
				wrte_pkg::ACT_DROP: begin
					head_q <= head_inc;
					cnt_q  <= cnt_q - 1'b1;
				end
				wrte_pkg::ACT_REBASE: begin
					origin_q <= origin_q + ox_q;
					sx_q     <= '0;
					sxx_q    <= '0;
					sy_q     <= '0;
					sxy_q    <= '0;
				end
				wrte_pkg::ACT_SUMS: begin
					sx_q <= sub_q ? sx_q - wrte_pkg::SX_W'(curx_q) :
					                sx_q + wrte_pkg::SX_W'(curx_q);
					sy_q <= sub_q ? sy_q - wrte_pkg::SY_W'(cury_q) :
					                sy_q + wrte_pkg::SY_W'(cury_q);
				end
				wrte_pkg::ACT_ACC_XY: begin
					sxy_q <= sub_q ? sxy_q - mul_p[wrte_pkg::SXY_W-1:0] :
					                 sxy_q + mul_p[wrte_pkg::SXY_W-1:0];
				end
				wrte_pkg::ACT_ACC_XX: begin
					sxx_q <= sub_q ? sxx_q - mul_p[wrte_pkg::SXX_W-1:0] :
					                 sxx_q + mul_p[wrte_pkg::SXX_W-1:0];
				end
				wrte_pkg::ACT_LOG_X: cnt_q <= cnt_q + 1'b1;
				wrte_pkg::ACT_RES_EST, wrte_pkg::ACT_RES_NOEST: out_valid_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.act)
			wrte_pkg::ACT_LOAD: begin
				mode_q <= mode;
				now_q  <= now_ms;
				pct_q  <= pct_done;
			end
			wrte_pkg::ACT_DROP: begin
				ox_q <= rdx;
				oy_q <= rdy;
			end
			wrte_pkg::ACT_CUR_OLD: begin
				curx_q <= ox_q;
				cury_q <= oy_q;
				sub_q  <= 1'b1;
			end
			wrte_pkg::ACT_REBASE: begin
				k_q   <= head_q;
				rem_q <= cnt_q;
			end
			wrte_pkg::ACT_W_FIX: begin
				curx_q <= fix_x;
				cury_q <= rdy;
				sub_q  <= 1'b0;
			end
			wrte_pkg::ACT_W_NEXT: begin
				k_q   <= k_inc;
				rem_q <= rem_q - 1'b1;
			end
			wrte_pkg::ACT_LOG_X: begin
				curx_q <= x_log;
				cury_q <= pct_q;
				sub_q  <= 1'b0;
			end
			wrte_pkg::ACT_R1: r1_q <= mul_p;
			wrte_pkg::ACT_D: d_q <= wrte_pkg::D_W'(r1_q - mul_p);
			wrte_pkg::ACT_N: begin
				nneg_q <= t_d12[wrte_pkg::P_W];
				nmag_q <= t_d12[wrte_pkg::P_W] ? wrte_pkg::NMAG_W'(t_d21) :
				                                 wrte_pkg::NMAG_W'(t_d12);
			end
			wrte_pkg::ACT_NUM: begin
				num_q    <= num_d;
				numneg_q <= numneg_d;
			end
			wrte_pkg::ACT_RES_EST: begin
				est_q <= est_d;
				has_q <= 1'b1;
			end
			wrte_pkg::ACT_RES_NOEST: begin
				est_q <= noest;
				has_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		sts.mode      = mode_q;
		sts.cnt_zero  = (cnt_q == '0);
		sts.cnt_full  = (cnt_q == FULL_CNT);
		sts.cnt_lt2   = (cnt_q < CNT_W'(2));
		sts.old_below = (ox_q < thr);
		sts.walk_last = (rem_q == CNT_W'(1));
		sts.d_zero    = (d_q == '0);
		sts.n_eq      = (r1_q == mul_p);
		sts.mul_busy  = mul_busy;
		sts.div_busy  = div_busy;
		sts.out_busy  = out_valid_q;
	end

	assign out_valid    = out_valid_q;
	assign remaining_ms = est_q;
	assign has_estimate = has_q;

endmodule

// ===== rtl/core/wrte_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrte_ctrl: estimator sequencer
// Walks log, drop/rebase and fit steps, issuing one datapath action per cycle except while it waits on a busy unit.
// ----------------------------------------------------------------------------
module wrte_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  wrte_pkg::sts_t sts,
	output wrte_pkg::cmd_t cmd
);

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE   = 5'd0;
	localparam logic [ST_W-1:0] ST_DISP   = 5'd1;
	localparam logic [ST_W-1:0] ST_DROP_W = 5'd2;
	localparam logic [ST_W-1:0] ST_DROP_C = 5'd3;
	localparam logic [ST_W-1:0] ST_U_XY   = 5'd4;
	localparam logic [ST_W-1:0] ST_U_XY_W = 5'd5;
	localparam logic [ST_W-1:0] ST_U_XX   = 5'd6;
	localparam logic [ST_W-1:0] ST_U_XX_W = 5'd7;
	localparam logic [ST_W-1:0] ST_W_RD   = 5'd8;
	localparam logic [ST_W-1:0] ST_W_WAIT = 5'd9;
	localparam logic [ST_W-1:0] ST_W_NEXT = 5'd10;
	localparam logic [ST_W-1:0] ST_LOG_X  = 5'd11;
	localparam logic [ST_W-1:0] ST_Q0     = 5'd12;
	localparam logic [ST_W-1:0] ST_Q1     = 5'd13;
	localparam logic [ST_W-1:0] ST_Q2     = 5'd14;
	localparam logic [ST_W-1:0] ST_Q3     = 5'd15;
	localparam logic [ST_W-1:0] ST_Q4     = 5'd16;
	localparam logic [ST_W-1:0] ST_Q5     = 5'd17;
	localparam logic [ST_W-1:0] ST_Q6     = 5'd18;
	localparam logic [ST_W-1:0] ST_Q7     = 5'd19;
	localparam logic [ST_W-1:0] ST_Q8     = 5'd20;
	localparam logic [ST_W-1:0] ST_Q9     = 5'd21;
	localparam logic [ST_W-1:0] ST_Q10    = 5'd22;
	localparam logic [ST_W-1:0] ST_Q11    = 5'd23;
	localparam logic [ST_W-1:0] ST_Q12    = 5'd24;
	localparam logic [ST_W-1:0] ST_Q13    = 5'd25;
	localparam logic [ST_W-1:0] ST_Q14    = 5'd26;
	localparam logic [ST_W-1:0] ST_RES    = 5'd27;
	localparam logic [ST_W-1:0] ST_NOEST  = 5'd28;

	// where a sample update returns to
	localparam logic [1:0] RET_LOGX = 2'd0;
	localparam logic [1:0] RET_WALK = 2'd1;
	localparam logic [1:0] RET_DONE = 2'd2;

	logic [ST_W-1:0] state_q, state_d;
	logic [1:0]      ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_DONE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ret_d         = ret_q;
		cmd.act       = wrte_pkg::ACT_NONE;
		cmd.mul_start = 1'b0;
		cmd.mop       = wrte_pkg::MOP_XY;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.act = wrte_pkg::ACT_LOAD;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				if (sts.mode) begin
					state_d = ST_Q0;
				end else if (sts.cnt_zero) begin
					cmd.act = wrte_pkg::ACT_SET_ORIGIN;
					state_d = ST_LOG_X;
				end else if (sts.cnt_full) begin
					cmd.act = wrte_pkg::ACT_RD_HEAD;
					state_d = ST_DROP_W;
				end else begin
					state_d = ST_LOG_X;
				end
			end
			ST_DROP_W: begin
				cmd.act = wrte_pkg::ACT_DROP;
				state_d = ST_DROP_C;
			end
			ST_DROP_C: begin
				if (sts.old_below) begin
					cmd.act = wrte_pkg::ACT_CUR_OLD;
					ret_d   = RET_LOGX;
					state_d = ST_U_XY;
				end else begin
					cmd.act = wrte_pkg::ACT_REBASE;
					state_d = ST_W_RD;
				end
			end
			ST_U_XY: begin
				cmd.act       = wrte_pkg::ACT_SUMS;
				cmd.mul_start = 1'b1;
				cmd.mop       = wrte_pkg::MOP_XY;
				state_d       = ST_U_XY_W;
			end
			ST_U_XY_W: begin
				if (!sts.mul_busy) begin
					cmd.act = wrte_pkg::ACT_ACC_XY;
					state_d = ST_U_XX;
				end
			end
			ST_U_XX: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = wrte_pkg::MOP_XX;
				state_d       = ST_U_XX_W;
			end
			ST_U_XX_W: begin
				if (!sts.mul_busy) begin
					cmd.act = wrte_pkg::ACT_ACC_XX;
					case (ret_q)
						RET_LOGX: state_d = ST_LOG_X;
						RET_WALK: state_d = ST_W_NEXT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_W_RD: begin
				cmd.act = wrte_pkg::ACT_W_RD;
				state_d = ST_W_WAIT;
			end
			ST_W_WAIT: begin
				cmd.act = wrte_pkg::ACT_W_FIX;
				ret_d   = RET_WALK;
				state_d = ST_U_XY;
			end
			ST_W_NEXT: begin
				cmd.act = wrte_pkg::ACT_W_NEXT;
				state_d = sts.walk_last ? ST_LOG_X : ST_W_RD;
			end
			ST_LOG_X: begin
				cmd.act = wrte_pkg::ACT_LOG_X;
				ret_d   = RET_DONE;
				state_d = ST_U_XY;
			end
			ST_Q0: begin
				if (sts.cnt_lt2) begin
					state_d = ST_NOEST;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mop       = wrte_pkg::MOP_N_SXX;
					state_d       = ST_Q1;
				end
			end
			ST_Q1: begin
				if (!sts.mul_busy) begin
					cmd.act = wrte_pkg::ACT_R1;
					state_d = ST_Q2;
				end
			end
			ST_Q2: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = wrte_pkg::MOP_SX_SX;
				state_d       = ST_Q3;
			end
			ST_Q3: begin
				if (!sts.mul_busy) begin
					cmd.act = wrte_pkg::ACT_D;
					state_d = ST_Q4;
				end
			end
			ST_Q4: begin
				if (sts.d_zero) begin
					state_d = ST_NOEST;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mop       = wrte_pkg::MOP_N_SXY;
					state_d       = ST_Q5;
				end
			end
			ST_Q5: begin
				if (!sts.mul_busy) begin
					cmd.act = wrte_pkg::ACT_R1;
					state_d = ST_Q6;
				end
			end
			ST_Q6: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = wrte_pkg::MOP_SX_SY;
				state_d       = ST_Q7;
			end
			ST_Q7: begin
				if (!sts.mul_busy) begin
					if (sts.n_eq) begin
						state_d = ST_NOEST;
					end else begin
						cmd.act = wrte_pkg::ACT_N;
						state_d = ST_Q8;
					end
				end
			end
			ST_Q8: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = wrte_pkg::MOP_SX_NMAG;
				state_d       = ST_Q9;
			end
			ST_Q9: begin
				if (!sts.mul_busy) begin
					cmd.act = wrte_pkg::ACT_R1;
					state_d = ST_Q10;
				end
			end
			ST_Q10: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = wrte_pkg::MOP_D_PMAG;
				state_d       = ST_Q11;
			end
			ST_Q11: begin
				if (!sts.mul_busy) begin
					cmd.act = wrte_pkg::ACT_NUM;
					state_d = ST_Q12;
				end
			end
			ST_Q12: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = wrte_pkg::MOP_N_NMAG;
				state_d       = ST_Q13;
			end
			ST_Q13: begin
				if (!sts.mul_busy) begin
					cmd.act = wrte_pkg::ACT_DIV;
					state_d = ST_Q14;
				end
			end
			ST_Q14: begin
				if (!sts.div_busy) begin
					state_d = ST_RES;
				end
			end
			ST_RES: begin
				if (!sts.out_busy) begin
					cmd.act = wrte_pkg::ACT_RES_EST;
					state_d = ST_IDLE;
				end
			end
			ST_NOEST: begin
				if (!sts.out_busy) begin
					cmd.act = wrte_pkg::ACT_RES_NOEST;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

// ===== dv/window_regression_time_estimator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_regression_time_estimator_checker
// Watches the request, result and register-write ports of the estimator, keeps
// its own copy of the sample window and running sums, fits the line for each
// query and compares every returned estimate with the oldest one predicted.
// ----------------------------------------------------------------------------
module window_regression_time_estimator_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           mode,
	input  logic [wrte_pkg::X_W-1:0]       now_ms,
	input  logic [wrte_pkg::Y_W-1:0]       pct_done,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [wrte_pkg::X_W-1:0]       remaining_ms,
	input  logic                           has_estimate,
	input  logic                           cfg_we,
	input  logic [wrte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wrte_pkg::X_W-1:0]       cfg_data,
	output int                             errors,
	output int                             pending
);
	import wrte_pkg::*;

	localparam int WIN = WINDOW_DEF;

	typedef struct {
		logic [X_W-1:0] ms;
		logic           valid_fit;
	} estimate_t;

	estimate_t      estimates_q[$];
	logic [31:0]    thr_ms;
	logic [31:0]    noest_ms;
	logic [31:0]    origin;
	logic [31:0]    win_x[WIN];
	logic [31:0]    win_y[WIN];
	int             head;
	int             count;
	logic [63:0]    sx, sy, sxy;

	assign pending = estimates_q.size();

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic sums_add(input logic [31:0] x, input logic [31:0] y);
		sx  += 64'(x);
		sy  += 64'(y);
		sxy += 64'(x) * 64'(y);
	endtask

	task automatic drop_oldest();
		logic [31:0] old_x, old_y;
		int k;
		old_x = win_x[head];
		old_y = win_y[head];
		head  = (head + 1) % WIN;
		count--;
		if (old_x < thr_ms) begin
			sx  -= 64'(old_x);
			sy  -= 64'(old_y);
			sxy -= 64'(old_x) * 64'(old_y);
		end else begin
			// origin moves up; all kept times shift and the sums are rebuilt
			origin += old_x;
			sx = 0; sy = 0; sxy = 0;
			for (int i = 0; i < count; i++) begin
				k = (head + i) % WIN;
				win_x[k] -= old_x;
				sums_add(win_x[k], win_y[k]);
			end
		end
	endtask

	task automatic log_sample(input logic [31:0] now, input logic [31:0] pct);
		int slot;
		if (count == 0)
			origin = now;
		else if (count >= WIN)
			drop_oldest();
		slot = (head + count) % WIN;
		win_x[slot] = now - origin;
		win_y[slot] = pct;
		count++;
		sums_add(win_x[slot], pct);
	endtask

	function automatic estimate_t fit_line(input logic [31:0] now);
		estimate_t     r;
		logic [63:0]   n, a1, a2, nmag, pmag, dden, dx;
		logic [127:0]  dsum, t1, t2, num, q, diff;
		logic [31:0]   xi, xj, xnow;
		bit            n_neg, p_neg, num_neg;
		r.ms = noest_ms;
		r.valid_fit = 1'b0;
		n = 64'(count);
		if (count < 2)
			return r;
		dsum = '0;
		for (int i = 0; i < count; i++)
			for (int j = i + 1; j < count; j++) begin
				xi = win_x[(head + i) % WIN];
				xj = win_x[(head + j) % WIN];
				dx = (xi >= xj) ? 64'(xi - xj) : 64'(xj - xi);
				dsum += 128'(dx) * 128'(dx);
			end
		if (dsum == 0)
			return r;
		a1 = n * sxy;
		a2 = sx * sy;
		if (a1 == a2)
			return r;
		n_neg = a1 < a2;
		nmag  = n_neg ? a2 - a1 : a1 - a2;
		a1    = 64'(PCT_FULL) * n;
		p_neg = a1 < sy;
		pmag  = p_neg ? sy - a1 : a1 - sy;
		t1 = 128'(sx) * 128'(nmag);
		t2 = dsum * 128'(pmag);
		num_neg = 1'b0;
		if (n_neg == p_neg)
			num = t1 + t2;
		else if (t1 >= t2)
			num = t1 - t2;
		else begin
			num = t2 - t1;
			num_neg = 1'b1;
		end
		dden = n * nmag;
		q    = num / 128'(dden);
		xnow = now - origin;
		r.valid_fit = 1'b1;
		if (num_neg || q <= 128'(xnow))
			r.ms = '0;
		else begin
			diff = q - 128'(xnow);
			r.ms = (diff > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		estimate_t got;
		estimate_t want;
		if (!arst_n) begin
			errors   = 0;
			thr_ms   = THR_RST;
			noest_ms = NOEST_RST;
			origin   = '0;
			head     = 0;
			count    = 0;
			sx = 0; sy = 0; sxy = 0;
			for (int i = 0; i < WIN; i++) begin
				win_x[i] = '0;
				win_y[i] = '0;
			end
			estimates_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				got.ms = remaining_ms;
				got.valid_fit = has_estimate;
				if (estimates_q.size() == 0)
					report($sformatf("unexpected result %0d/%0b", got.ms, got.valid_fit));
				else begin
					want = estimates_q.pop_front();
					if (got.ms !== want.ms)
						report($sformatf("remaining_ms %0d, want %0d", got.ms, want.ms));
					if (got.valid_fit !== want.valid_fit)
						report($sformatf("has_estimate %0b, want %0b",
							got.valid_fit, want.valid_fit));
				end
			end
			if (in_valid && in_ready) begin
				if (mode)
					estimates_q.push_back(fit_line(now_ms));
				else
					log_sample(now_ms, 32'(pct_done));
			end
			if (cfg_we) begin
				if (cfg_index == CFG_THR)
					thr_ms = cfg_data;
				else if (cfg_index == CFG_NOEST)
					noest_ms = cfg_data;
			end
		end
	end

endmodule

// ===== dv/window_regression_time_estimator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_regression_time_estimator_tb
// Drives log and query requests with random gaps and result back-pressure,
// walks the rebase threshold and default estimate through several settings,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module window_regression_time_estimator_tb;
	import wrte_pkg::*;

	localparam logic MODE_LOG   = 1'b0;
	localparam logic MODE_QUERY = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 mode = MODE_LOG;
	logic [X_W-1:0]       now_ms = '0;
	logic [Y_W-1:0]       pct_done = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [X_W-1:0]       remaining_ms;
	logic                 has_estimate;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [X_W-1:0]       cfg_data = '0;
	int                   errors;
	int                   pending;

	bit          calm = 1'b0;
	bit          squeeze = 1'b0;
	logic [31:0] job_ms = 32'd1000;
	logic [13:0] job_pct = '0;

	always #1 clk = ~clk;

	window_regression_time_estimator dut (.*);

	window_regression_time_estimator_checker chk (.*);

	// ready is looked at on the falling edge, where it is settled
	task automatic send(input logic m, input logic [31:0] t, input logic [13:0] p);
		if (!calm && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end else
			@(negedge clk);
		in_valid = 1'b1;
		mode     = m;
		now_ms   = t;
		pct_done = p;
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// results drained, then room for a rebase walk still running after a log
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2000) @(negedge clk);
	endtask

	// one request of a plausible job: mostly rising time and progress
	task automatic random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			job_ms  += (r < 3) ? $urandom_range(500000, 2000000) : $urandom_range(50, 5000);
			job_pct += 14'($urandom_range(0, 150));
			if (job_pct > 14'd10000) job_pct = 14'd500;
			send(MODE_LOG, job_ms, job_pct);
		end else if (r < 85)
			send(MODE_QUERY, job_ms + $urandom_range(0, 3000), 14'($urandom));
		else if (r < 92)
			send(MODE_LOG, $urandom, 14'($urandom));
		else
			send(MODE_QUERY, $urandom, 14'($urandom));
	endtask

	// result side: random stalls, one long hold-off when asked
	initial begin
		bit held = 1'b0;
		int hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze && !held) begin
				held = 1'b1;
				out_ready = 1'b0;
				for (hold = 0; hold < 3000; hold++) @(negedge clk);
			end
			if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	initial begin
		#6_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [31:0] thr_set[4];
		logic [31:0] noest_set[4];
		thr_set   = '{32'd800000, 32'd1, 32'hFFFF_FFFF, 32'd20000};
		noest_set = '{32'd60000, 32'd0, 32'hFFFF_FFFF, 32'd12345};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty window, single sample, zero spread, flat and
		// falling progress, wrapped time, oversize percent, huge estimate
		send(MODE_QUERY, 32'd0, 14'd0);
		send(MODE_LOG, 32'hFFFF_FFF0, 14'd0);
		send(MODE_QUERY, 32'hFFFF_FFFF, 14'h3FFF);
		send(MODE_LOG, 32'hFFFF_FFF0, 14'd500);
		send(MODE_QUERY, 32'd5, 14'd0);
		send(MODE_LOG, 32'd100, 14'd500);
		send(MODE_QUERY, 32'd200, 14'd0);
		send(MODE_LOG, 32'd300, 14'd100);
		send(MODE_QUERY, 32'd400, 14'd0);
		send(MODE_QUERY, 32'h7FFF_FFFF, 14'd0);
		send(MODE_LOG, 32'd400, 14'h3FFF);
		send(MODE_LOG, 32'd500, 14'd16000);
		send(MODE_QUERY, 32'd600, 14'd0);
		send(MODE_QUERY, 32'hFFFF_FFFF, 14'd0);
		send(MODE_LOG, 32'hFFFF_FFFF, 14'd16001);
		send(MODE_QUERY, 32'd0, 14'd0);
		send(MODE_LOG, 32'h8000_0000, 14'd16002);
		send(MODE_QUERY, 32'h8000_0001, 14'd0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_THR, thr_set[ph]);
			write_reg(CFG_NOEST, noest_set[ph]);
			if (ph == 1) write_reg(CFG_SPARE, $urandom);
			// a fresh slow-progress run pushes the fit toward saturation
			if (ph == 2)
				for (int i = 0; i < 22; i++) begin
					job_ms += 32'd40000;
					send(MODE_LOG, job_ms, 14'(i / 2));
				end
			for (int i = 0; i < 135; i++) begin
				if (ph == 0 && i == 40) squeeze = 1'b1;
				if (ph == 3 && i == 90) calm = 1'b1;
				random_request();
			end
			drain();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
